FILE: rtl/stc_pkg.sv
// ============================================================================
// stc_pkg: shared types and constants for the segment/triangle classifier
// Coordinate format, the point and sign types, and the relation codes.
// ============================================================================
package stc_pkg;

    // Signed Q12.4 coordinates.
    localparam int COORD_BITS = 16;

    // A difference of two coordinates, its products, and the cross product.
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    // Sign of a value: zero set means 0, otherwise neg tells the side.
    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

    // Signs of three points about one line.
    typedef struct packed {
        sign_t s0;
        sign_t s1;
        sign_t s2;
    } line_signs_t;

    // All twelve cross-product signs of one request.
    typedef struct packed {
        line_signs_t edge_ab;   // p0, p1, C about line A-B
        line_signs_t edge_bc;   // p0, p1, A about line B-C
        line_signs_t edge_ca;   // p0, p1, B about line C-A
        line_signs_t seg_line;  // A, B, C about the segment's line
    } cross_signs_t;

    typedef enum logic [1:0] {
        REL_APART   = 2'd0,
        REL_OVERLAP = 2'd1,
        REL_TOUCH   = 2'd2,
        REL_CROSS   = 2'd3
    } relation_t;

    // Sign of the product of two signed values, from their signs alone.
    function automatic sign_t sign_mul(input sign_t a, input sign_t b);
        sign_t r;
        r.zero = a.zero | b.zero;
        r.neg  = ~r.zero & (a.neg ^ b.neg);
        return r;
    endfunction

endpackage

FILE: rtl/stc_cross.sv
// ============================================================================
// stc_cross: sign of one exact 2D cross product
// Gives the side of a point relative to the directed line through two points.
// ============================================================================
module stc_cross (
    input  stc_pkg::point_t pt,
    input  stc_pkg::point_t line_a,
    input  stc_pkg::point_t line_b,
    output stc_pkg::sign_t  sgn
);

    logic signed [stc_pkg::DIFF_W-1:0]  dx;
    logic signed [stc_pkg::DIFF_W-1:0]  dy;
    logic signed [stc_pkg::DIFF_W-1:0]  px;
    logic signed [stc_pkg::DIFF_W-1:0]  py;
    logic signed [stc_pkg::PROD_W-1:0]  prod_a;
    logic signed [stc_pkg::PROD_W-1:0]  prod_b;
    logic signed [stc_pkg::CROSS_W-1:0] cross_val;

    assign dx = $signed({line_b.x[stc_pkg::COORD_BITS-1], line_b.x})
              - $signed({line_a.x[stc_pkg::COORD_BITS-1], line_a.x});
    assign dy = $signed({line_b.y[stc_pkg::COORD_BITS-1], line_b.y})
              - $signed({line_a.y[stc_pkg::COORD_BITS-1], line_a.y});
    assign px = $signed({pt.x[stc_pkg::COORD_BITS-1], pt.x})
              - $signed({line_a.x[stc_pkg::COORD_BITS-1], line_a.x});
    assign py = $signed({pt.y[stc_pkg::COORD_BITS-1], pt.y})
              - $signed({line_a.y[stc_pkg::COORD_BITS-1], line_a.y});

    // Both products fit exactly in PROD_W bits, the difference in one more.
    assign prod_a    = stc_pkg::PROD_W'(dx) * stc_pkg::PROD_W'(py);
    assign prod_b    = stc_pkg::PROD_W'(px) * stc_pkg::PROD_W'(dy);
    assign cross_val = stc_pkg::CROSS_W'(prod_a) - stc_pkg::CROSS_W'(prod_b);

    assign sgn.neg  = cross_val[stc_pkg::CROSS_W-1];
    assign sgn.zero = (cross_val == '0);

endmodule

FILE: rtl/stc_classify.sv
// ============================================================================
// stc_classify: relation decision from the side-test signs
// Forms the eight side tests and resolves them in priority order.
// ============================================================================
module stc_classify (
    input  stc_pkg::cross_signs_t signs,
    output stc_pkg::relation_t    relation
);

    stc_pkg::sign_t f1, f2, f3, f4, f5, f6, f7, f8;

    logic apart_strict;
    logic aligned;
    logic apart_loose;
    logic inside_strict;

    assign f1 = stc_pkg::sign_mul(signs.edge_ab.s0, signs.edge_ab.s2);
    assign f2 = stc_pkg::sign_mul(signs.edge_ab.s1, signs.edge_ab.s2);
    assign f3 = stc_pkg::sign_mul(signs.edge_bc.s0, signs.edge_bc.s2);
    assign f4 = stc_pkg::sign_mul(signs.edge_bc.s1, signs.edge_bc.s2);
    assign f5 = stc_pkg::sign_mul(signs.edge_ca.s0, signs.edge_ca.s2);
    assign f6 = stc_pkg::sign_mul(signs.edge_ca.s1, signs.edge_ca.s2);
    assign f7 = stc_pkg::sign_mul(signs.seg_line.s0, signs.seg_line.s1);
    assign f8 = stc_pkg::sign_mul(signs.seg_line.s1, signs.seg_line.s2);

    // A test is positive when it is neither zero nor negative.
    assign apart_strict = (f1.neg & f2.neg) | (f3.neg & f4.neg) | (f5.neg & f6.neg)
                        | (~f7.neg & ~f7.zero & ~f8.neg & ~f8.zero);
    assign aligned      = (f1.zero & f2.zero) | (f3.zero & f4.zero)
                        | (f5.zero & f6.zero);
    assign apart_loose  = ((f1.neg | f1.zero) & (f2.neg | f2.zero))
                        | ((f3.neg | f3.zero) & (f4.neg | f4.zero))
                        | ((f5.neg | f5.zero) & (f6.neg | f6.zero))
                        | (~f7.neg & ~f8.neg);
    assign inside_strict = ~(f1.neg | f1.zero | f2.neg | f2.zero
                           | f3.neg | f3.zero | f4.neg | f4.zero
                           | f5.neg | f5.zero | f6.neg | f6.zero);

    always_comb
    begin
        priority if (apart_strict)
        begin
            relation = stc_pkg::REL_APART;
        end
        else if (aligned)
        begin
            relation = stc_pkg::REL_OVERLAP;
        end
        else if (apart_loose)
        begin
            relation = stc_pkg::REL_TOUCH;
        end
        else if (inside_strict)
        begin
            relation = stc_pkg::REL_APART;
        end
        else
        begin
            relation = stc_pkg::REL_CROSS;
        end
    end

endmodule

FILE: rtl/segment_triangle_classify.sv
// ============================================================================
// segment_triangle_classify: 2D segment against triangle relation
// A request is captured in the input registers; its relation is computed from
// them and captured in the result register. One request per cycle while the
// result is not stalled; the twelve parallel cross products between the input
// and result registers set the cycle time.
// Reset clears both valid flags; payload registers are not reset.
// ============================================================================
module segment_triangle_classify (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic signed [stc_pkg::COORD_BITS-1:0] seg_start_x,
    input  logic signed [stc_pkg::COORD_BITS-1:0] seg_start_y,
    input  logic signed [stc_pkg::COORD_BITS-1:0] seg_end_x,
    input  logic signed [stc_pkg::COORD_BITS-1:0] seg_end_y,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_a_x,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_a_y,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_b_x,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_b_y,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_c_x,
    input  logic signed [stc_pkg::COORD_BITS-1:0] tri_c_y,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [1:0]                           relation
);

    stc_pkg::point_t p0_reg, p1_reg, ta_reg, tb_reg, tc_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    logic            res_valid_reg;
    logic            res_valid_next;
    logic [1:0]      relation_reg;
    logic [1:0]      relation_next;

    logic                  req_accept;
    logic                  res_advance;
    stc_pkg::cross_signs_t signs;
    stc_pkg::relation_t    relation_calc;

    // The result register frees up when it is empty or being taken.
    assign res_advance = ~res_valid_reg | ~res_stall;
    assign req_stall   = in_valid_reg & ~res_advance;
    assign req_accept  = req_valid & ~req_stall;

    assign in_valid_next  = req_stall ? in_valid_reg : req_valid;
    assign res_valid_next = res_advance ? in_valid_reg : res_valid_reg;
    assign relation_next  = (res_advance & in_valid_reg) ? 2'(relation_calc) : relation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            p0_reg <= '{x: seg_start_x, y: seg_start_y};
            p1_reg <= '{x: seg_end_x,   y: seg_end_y};
            ta_reg <= '{x: tri_a_x,     y: tri_a_y};
            tb_reg <= '{x: tri_b_x,     y: tri_b_y};
            tc_reg <= '{x: tri_c_x,     y: tri_c_y};
        end
        relation_reg <= relation_next;
    end

    // Edge A-B.
    stc_cross u_ab_p0 (.pt(p0_reg), .line_a(ta_reg), .line_b(tb_reg), .sgn(signs.edge_ab.s0));
    stc_cross u_ab_p1 (.pt(p1_reg), .line_a(ta_reg), .line_b(tb_reg), .sgn(signs.edge_ab.s1));
    stc_cross u_ab_c  (.pt(tc_reg), .line_a(ta_reg), .line_b(tb_reg), .sgn(signs.edge_ab.s2));

    // Edge B-C.
    stc_cross u_bc_p0 (.pt(p0_reg), .line_a(tb_reg), .line_b(tc_reg), .sgn(signs.edge_bc.s0));
    stc_cross u_bc_p1 (.pt(p1_reg), .line_a(tb_reg), .line_b(tc_reg), .sgn(signs.edge_bc.s1));
    stc_cross u_bc_a  (.pt(ta_reg), .line_a(tb_reg), .line_b(tc_reg), .sgn(signs.edge_bc.s2));

    // Edge C-A.
    stc_cross u_ca_p0 (.pt(p0_reg), .line_a(tc_reg), .line_b(ta_reg), .sgn(signs.edge_ca.s0));
    stc_cross u_ca_p1 (.pt(p1_reg), .line_a(tc_reg), .line_b(ta_reg), .sgn(signs.edge_ca.s1));
    stc_cross u_ca_b  (.pt(tb_reg), .line_a(tc_reg), .line_b(ta_reg), .sgn(signs.edge_ca.s2));

    // The segment's own line.
    stc_cross u_sg_a  (.pt(ta_reg), .line_a(p0_reg), .line_b(p1_reg), .sgn(signs.seg_line.s0));
    stc_cross u_sg_b  (.pt(tb_reg), .line_a(p0_reg), .line_b(p1_reg), .sgn(signs.seg_line.s1));
    stc_cross u_sg_c  (.pt(tc_reg), .line_a(p0_reg), .line_b(p1_reg), .sgn(signs.seg_line.s2));

    stc_classify u_classify (
        .signs    (signs),
        .relation (relation_calc)
    );

    assign res_valid = res_valid_reg;
    assign relation  = relation_reg;

    // A request is only held off while the input stage is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg)
        else $error("request stalled with an empty input stage");

    // A full input stage facing a stalled result keeps its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && res_valid_reg && res_stall |=> in_valid_reg)
        else $error("input stage dropped a request while the result was stalled");

    // A full input stage with a free result register yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (!res_valid_reg || !res_stall) |=> res_valid_reg)
        else $error("input stage did not move to the result register");

    // A taken result with nothing behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_stall && !in_valid_reg |=> !res_valid_reg)
        else $error("result repeated after it was taken");

endmodule
